@@ design/assert_macros.svh @@
// assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge, reset held or not
`define OUSD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
// property checked only while out of reset
`define OUSD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define OUSD_ASSERT_ALWAYS(label, clk, prop, msg)
`define OUSD_ASSERT(label, clk, rst_n, prop, msg)
`endif
`endif

@@ design/ousd_pkg.sv @@
// shared types and codes for the ordered unique set
package ousd_pkg;

  localparam int unsigned TagW    = 32;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD      = 3'd0,
    MODE_POP_NEW  = 3'd1,
    MODE_POP_OLD  = 3'd2,
    MODE_QUERY    = 3'd3,
    MODE_DELETE   = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic            pop_old;  // shift the whole row toward slot zero
    logic            del;      // shift the cells at and above the match
    logic [TagW-1:0] key;      // tag to compare and to write
  } cell_ctrl_t;

endpackage

@@ design/ordered_unique_set_deque_core.sv @@
// top level of the ordered unique set: cell row, fill count and result register
// each accepted request's result is held in the result register until it is taken
// throughput: one request per cycle while the result side takes each result
// the parallel compare and the hit chain across all cells set the cycle time
// reset clears the fill count and the result valid; slot tags stay unwritten
// no clearing pass follows reset, requests are taken at once
module ordered_unique_set_deque_core #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ousd_pkg::ModeW-1:0]   mode_i,
  input  logic [ousd_pkg::TagW-1:0]    tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ousd_pkg::StatusW-1:0] status_o,
  output logic [ousd_pkg::TagW-1:0]    popped_tag_o,
  output logic                         present_o,
  output logic [CntW-1:0]              occupancy_o
);
  import ousd_pkg::*;

  `include "assert_macros.svh"

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  logic [StatusW-1:0]  status_q, status_d;
  logic [TagW-1:0]     popped_q, popped_d;
  logic                present_q, present_d;

  logic [TagW-1:0]     cell_tag [CAPACITY];
  logic [CAPACITY:0]   hit_chain;
  logic [CAPACITY-1:0] cell_match, cell_valid, cell_wr, cell_last;
  logic [TagW-1:0]     newest_tag;
  cell_ctrl_t          ctrl;
  logic                accept, any_hit, empty, full, add_ok;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign any_hit    = hit_chain[CAPACITY];
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(CAPACITY));
  assign add_ok     = accept && (mode_i == MODE_ADD) && !any_hit && !full;

  // broadcast control for the row
  always_comb begin
    ctrl.key     = tag_i;
    ctrl.pop_old = accept && (mode_i == MODE_POP_OLD) && !empty;
    ctrl.del     = accept && (mode_i == MODE_DELETE);
  end

  assign hit_chain[0] = 1'b0;

  // row of cells, slot zero holds the oldest entry
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [TagW-1:0] next_tag;

    assign cell_valid[i] = (CntW'(i) < count_q);
    assign cell_wr[i]    = add_ok && (CntW'(i) == count_q);
    assign next_tag      = (i == CAPACITY - 1) ? cell_tag[i] : cell_tag[(i + 1) % CAPACITY];

    ousd_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (cell_valid[i]),
      .wr_i       (cell_wr[i]),
      .next_tag_i (next_tag),
      .hit_i      (hit_chain[i]),
      .tag_o      (cell_tag[i]),
      .hit_o      (hit_chain[i+1]),
      .match_o    (cell_match[i])
    );

    // newest entry is the valid slot whose upper neighbor is empty
    if (i == CAPACITY - 1) begin : g_top
      assign cell_last[i] = cell_valid[i];
    end else begin : g_mid
      assign cell_last[i] = cell_valid[i] && !cell_valid[i+1];
    end
  end

  // pick the newest tag by or-ing the masked slots
  always_comb begin
    newest_tag = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      newest_tag = newest_tag | (cell_tag[k] & {TagW{cell_last[k]}});
    end
  end

  // result and fill count for the accepted request
  always_comb begin
    status_d  = ST_OK;
    popped_d  = '0;
    present_d = 1'b0;
    count_d   = count_q;
    case (mode_i)
      MODE_ADD: begin
        if (any_hit) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      MODE_POP_NEW: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = newest_tag;
          count_d  = count_q - CntW'(1);
        end
      end
      MODE_POP_OLD: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          popped_d = cell_tag[0];
          count_d  = count_q - CntW'(1);
        end
      end
      MODE_QUERY: begin
        present_d = any_hit;
      end
      MODE_DELETE: begin
        if (any_hit) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      popped_q  <= popped_d;
      present_q <= present_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign popped_tag_o = popped_q;
  assign present_o    = present_q;
  assign occupancy_o  = count_q;

  `OUSD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY), "fill count above capacity")
  `OUSD_ASSERT(a_unique_match, clk_i, rst_ni, $onehot0(cell_match), "tag held in two slots")
  `OUSD_ASSERT(a_result_follows, clk_i, rst_ni, accept |=> out_valid_q, "request gave no result")
  `OUSD_ASSERT(a_add_grows, clk_i, rst_ni, add_ok |=> (count_q == $past(count_q) + CntW'(1)), "add did not grow the set")

endmodule

@@ design/ousd_cell.sv @@
// one slot of the set: holds a tag, compares it and shifts toward slot zero
module ousd_cell (
  input  logic                      clk_i,
  input  ousd_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      valid_i,
  input  logic                      wr_i,
  input  logic [ousd_pkg::TagW-1:0] next_tag_i,
  input  logic                      hit_i,
  output logic [ousd_pkg::TagW-1:0] tag_o,
  output logic                      hit_o,
  output logic                      match_o
);
  import ousd_pkg::*;

  logic [TagW-1:0] tag_q, tag_d;
  logic            shift;

  // compare against the key only while the slot holds an entry
  assign match_o = valid_i && (tag_q == ctrl_i.key);
  assign hit_o   = hit_i | match_o;

  // take the neighbor's tag when the row closes a gap at or below this slot
  assign shift = ctrl_i.pop_old | (ctrl_i.del & hit_o);

  always_comb begin
    tag_d = tag_q;
    if (shift) begin
      tag_d = next_tag_i;
    end else if (wr_i) begin
      tag_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign tag_o = tag_q;

endmodule

@@ sim/ordered_unique_set_deque_core_test.sv @@
// testbench for the ordered unique set core: directed and random requests checked by a predictor
`timescale 1ns / 1ps

module ordered_unique_set_deque_core_test;
  import ousd_pkg::*;

  localparam int unsigned Capacity = 16;
  localparam int unsigned OccW     = $clog2(Capacity + 1);
  localparam int unsigned RandReqs = 1420;
  localparam int unsigned PoolSize = 24;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [ModeW-1:0] ModeSpareLo = ModeW'(MODE_DELETE + 1);
  localparam logic [ModeW-1:0] ModeSpareHi = '1;

  typedef struct {
    logic [ModeW-1:0] mode;
    logic [TagW-1:0]  tag;
    int               gap;   // idle cycles after this request
  } set_req_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [TagW-1:0]    popped_tag;
    logic               present;
    logic [OccW-1:0]    occupancy;
  } set_result_t;

  // clock, reset and block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ModeW-1:0] mode_i = '0;
  logic [TagW-1:0] tag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [TagW-1:0] popped_tag_o;
  logic present_o;
  logic [OccW-1:0] occupancy_o;

  // request stream, predicted results and predictor state
  set_req_t pending_reqs[$];
  set_result_t expected_results[$];
  logic [TagW-1:0] held_tags[$];
  logic [TagW-1:0] tag_pool[PoolSize];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int idle_left = 0;
  int stall_left = 0;
  int mode_seen[8];
  int status_seen[8];
  int peak_fill = 0;
  int checked_cnt = 0;

  ordered_unique_set_deque_core #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .tag_i       (tag_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .popped_tag_o(popped_tag_o),
    .present_o   (present_o),
    .occupancy_o (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // apply one request to the shadow set and return what the block should report
  function automatic set_result_t apply_set_request(logic [ModeW-1:0] mode,
                                                    logic [TagW-1:0] tag);
    set_result_t res;
    int hit;
    res.status = ST_OK;
    res.popped_tag = '0;
    res.present = 1'b0;
    hit = -1;
    foreach (held_tags[i]) begin
      if (hit < 0 && held_tags[i] == tag) hit = i;
    end
    case (mode)
      MODE_ADD: begin
        if (hit >= 0) res.status = ST_DUP;
        else if (held_tags.size() >= Capacity) res.status = ST_FULL;
        else held_tags.push_back(tag);
      end
      MODE_POP_NEW: begin
        if (held_tags.size() == 0) res.status = ST_EMPTY;
        else res.popped_tag = held_tags.pop_back();
      end
      MODE_POP_OLD: begin
        if (held_tags.size() == 0) res.status = ST_EMPTY;
        else res.popped_tag = held_tags.pop_front();
      end
      MODE_QUERY: res.present = (hit >= 0);
      MODE_DELETE: begin
        if (hit < 0) res.status = ST_NOTFOUND;
        else held_tags.delete(hit);
      end
      default: ;
    endcase
    res.occupancy = OccW'(held_tags.size());
    mode_seen[mode]++;
    status_seen[res.status]++;
    if (held_tags.size() > peak_fill) peak_fill = held_tags.size();
    return res;
  endfunction

  function automatic void queue_request(logic [ModeW-1:0] mode, logic [TagW-1:0] tag,
                                        int gap);
    set_req_t req;
    req.mode = mode;
    req.tag = tag;
    req.gap = gap;
    pending_reqs.push_back(req);
  endfunction

  // one random request, weighted toward filling, draining or a mix
  function automatic void queue_random_request(int bias, bit calm);
    int w_add, w_pnew, w_pold, w_qry, r;
    logic [ModeW-1:0] mode;
    logic [TagW-1:0] tag;
    case (bias)
      0:       begin w_add = 65; w_pnew = 8;  w_pold = 8;  w_qry = 10; end
      1:       begin w_add = 20; w_pnew = 22; w_pold = 22; w_qry = 12; end
      default: begin w_add = 35; w_pnew = 14; w_pold = 14; w_qry = 17; end
    endcase
    r = $urandom_range(0, 99);
    if (r < 2) mode = ModeW'($urandom_range(ModeSpareLo, ModeSpareHi));
    else if (r < 2 + w_add) mode = MODE_ADD;
    else if (r < 2 + w_add + w_pnew) mode = MODE_POP_NEW;
    else if (r < 2 + w_add + w_pnew + w_pold) mode = MODE_POP_OLD;
    else if (r < 2 + w_add + w_pnew + w_pold + w_qry) mode = MODE_QUERY;
    else mode = MODE_DELETE;
    // a small pool of tags makes hits and duplicates common
    if ($urandom_range(0, 99) < 85) tag = tag_pool[$urandom_range(0, PoolSize - 1)];
    else tag = $urandom;
    queue_request(mode, tag, calm ? 0 : pick_gap());
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= '0;
      tag_i <= '0;
      idle_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_set_request(mode_i, tag_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          mode_i <= pending_reqs[0].mode;
          tag_i <= pending_reqs[0].tag;
          idle_left = pending_reqs[0].gap;
          void'(pending_reqs.pop_front());
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d occupancy %0d",
                 status_o, occupancy_o);
          err_cnt++;
        end else begin
          checked_cnt++;
          if (status_o !== expected_results[0].status) begin
            $error("status: expected %0d, got %0d", expected_results[0].status, status_o);
            err_cnt++;
          end
          if (popped_tag_o !== expected_results[0].popped_tag) begin
            $error("popped_tag: expected %h, got %h",
                   expected_results[0].popped_tag, popped_tag_o);
            err_cnt++;
          end
          if (present_o !== expected_results[0].present) begin
            $error("present: expected %0d, got %0d", expected_results[0].present, present_o);
            err_cnt++;
          end
          if (occupancy_o !== expected_results[0].occupancy) begin
            $error("occupancy: expected %0d, got %0d",
                   expected_results[0].occupancy, occupancy_o);
            err_cnt++;
          end
          void'(expected_results.pop_front());
        end
      end
      // quiet windows in which no new receiver stall starts
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (((cycle_cnt / 512) % 4) != 1 && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
    end
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    for (int i = 0; i < PoolSize; i++) tag_pool[i] = $urandom;

    // empty store: both pops, a delete and a query
    queue_request(MODE_POP_NEW, 32'hDEAD_BEEF, 0);
    queue_request(MODE_POP_OLD, '0, 0);
    queue_request(MODE_DELETE, 32'h0000_0001, 0);
    queue_request(MODE_QUERY, '0, 0);
    // extreme tags and a duplicate
    queue_request(MODE_ADD, '0, 0);
    queue_request(MODE_ADD, '1, 0);
    queue_request(MODE_ADD, '0, 0);
    // fill to capacity
    for (int i = 1; i <= 14; i++) queue_request(MODE_ADD, i * 32'h1111_1111, 0);
    // full store: a new tag is refused, a held one reports duplicate
    queue_request(MODE_ADD, 32'h5555_AAAA, 0);
    queue_request(MODE_ADD, '1, 0);
    queue_request(MODE_QUERY, 32'h7777_7777, 0);
    queue_request(MODE_QUERY, 32'h5555_AAAA, 0);
    // delete from the middle, then take both ends
    queue_request(MODE_DELETE, 32'h3333_3333, 0);
    queue_request(MODE_POP_NEW, '1, 0);
    queue_request(MODE_POP_OLD, '1, 0);
    // unused mode codes
    queue_request(ModeSpareLo, '1, 0);
    queue_request(ModeSpareHi, '1, 0);

    // random phases of 60 requests, every fourth one with no sender gaps
    for (int i = 0; i < RandReqs; i++)
      queue_random_request((i / 60) % 3, ((i / 60) % 4) == 3);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    $display("checked %0d results: add %0d, pop newest %0d, pop oldest %0d,",
             checked_cnt, mode_seen[MODE_ADD], mode_seen[MODE_POP_NEW],
             mode_seen[MODE_POP_OLD]);
    $display("query %0d, delete %0d, spare modes %0d",
             mode_seen[MODE_QUERY], mode_seen[MODE_DELETE],
             mode_seen[5] + mode_seen[6] + mode_seen[7]);
    $display("duplicate %0d, not found %0d, empty %0d, full %0d, peak occupancy %0d",
             status_seen[ST_DUP], status_seen[ST_NOTFOUND], status_seen[ST_EMPTY],
             status_seen[ST_FULL], peak_fill);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
